// ===== sv/rcpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM decoder package
// Shared types, register indexes and constants of the pulse decoder.
// ----------------------------------------------------------------------------
package rcpd_pkg;

    typedef logic [15:0]        word_t;
    typedef logic signed [7:0]  pct_t;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MIN_WIDTH     = 3'd0;
    localparam cfg_idx_t REG_CENTER_WIDTH  = 3'd1;
    localparam cfg_idx_t REG_MAX_WIDTH     = 3'd2;
    localparam cfg_idx_t REG_DEAD_BAND     = 3'd3;
    localparam cfg_idx_t REG_TIMEOUT_LIMIT = 3'd4;

    localparam word_t MIN_WIDTH_RST     = 16'd1000;
    localparam word_t CENTER_WIDTH_RST  = 16'd1500;
    localparam word_t MAX_WIDTH_RST     = 16'd2000;
    localparam word_t DEAD_BAND_RST     = 16'd50;
    localparam word_t TIMEOUT_LIMIT_RST = 16'd50000;

    localparam word_t      SILENCE_CAP = 16'd60000;
    localparam logic [7:0] PCT_FULL    = 8'd100;

    // Scaled deviation: 16-bit magnitude times 100 fits in 23 bits
    localparam int NUM_W = 23;
    localparam int QUO_W = 7;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        word_t            den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/rcpd_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM decoder divider
// Restoring divider, one trial subtract per cycle; flags quotients of 128 up.
// ----------------------------------------------------------------------------
module rcpd_divider
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rcpd_pkg::div_req_t req,
    output rcpd_pkg::div_rsp_t    rsp
);
    import rcpd_pkg::*;

    logic             busy_reg, busy_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    word_t            den_reg, den_next;
    logic [QUO_W-1:0] quo_reg, quo_next;

    logic [NUM_W:0]   trial;
    logic             fits;
    logic             top_step;

    assign trial    = {1'b0, rem_reg} - ({{(NUM_W-15){1'b0}}, den_reg} << cnt_reg);
    assign fits     = !trial[NUM_W];
    assign top_step = (cnt_reg == 3'd7);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rsp.done  = 1'b0;
        rsp.sat   = 1'b0;
        rsp.quo   = quo_reg;
        if (busy_reg)
        begin
            if (top_step)
            begin
                if (fits)
                begin
                    rsp.done  = 1'b1;
                    rsp.sat   = 1'b1;
                    busy_next = 1'b0;
                end
                cnt_next = 3'd6;
            end
            else
            begin
                if (fits)
                begin
                    rem_next = trial[NUM_W-1:0];
                    quo_next = quo_reg | (QUO_W'(1) << cnt_reg);
                end
                rsp.quo = quo_next;
                if (cnt_reg == 3'd0)
                begin
                    rsp.done  = 1'b1;
                    busy_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd7;
            rem_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule
`default_nettype wire

// ===== sv/rc_pwm_pulse_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM pulse decoder
// Two-channel pulse width capture with timeout and percent scaling.
// ----------------------------------------------------------------------------
// An item updates both channels' edge state and silence counters in the cycle
// it is accepted, then reports the chosen channel. Each item is accepted,
// then the scaled deviation is formed; unless the percent is zero, the
// divider then runs up to 8 steps of its shared subtract unit, and last the
// result is loaded into the output register once that is free. The
// result waits in the output register, so the next item can be taken while it
// is still pending. Configuration writes are taken every cycle.
module rc_pwm_pulse_decoder_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire rcpd_pkg::cfg_idx_t cfg_index,
    input  wire rcpd_pkg::word_t    cfg_data,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic               first_edge_seen,
    input  wire rcpd_pkg::word_t    first_edge_time,
    input  wire logic               second_edge_seen,
    input  wire rcpd_pkg::word_t    second_edge_time,
    input  wire logic               overflow_tick,
    input  wire logic               report_channel,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      rcpd_pkg::word_t    width,
    output      rcpd_pkg::pct_t     percent,
    output      logic               signal_ok
);
    import rcpd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    word_t min_width_reg, center_width_reg, max_width_reg;
    word_t dead_band_reg, timeout_limit_reg;

    word_t rise_stamp_reg    [2];
    logic  await_fall_reg    [2];
    word_t pulse_width_reg   [2];
    word_t silence_count_reg [2];
    word_t rise_stamp_next    [2];
    logic  await_fall_next    [2];
    word_t pulse_width_next   [2];
    word_t silence_count_next [2];

    logic  edge_seen [2];
    word_t edge_time [2];

    logic  sel_reg;
    logic  neg_reg, neg_next;
    word_t res_width_reg, res_width_next;
    logic  res_ok_reg, res_ok_next;
    pct_t  pct_reg, pct_next;

    logic  out_valid_reg;
    word_t width_reg;
    pct_t  percent_reg;
    logic  signal_ok_reg;
    logic  out_load;

    logic  accept;
    word_t pw;
    logic  in_range, upper, lower;
    word_t den, mag;
    logic [NUM_W-1:0] num;
    logic  zero_pct;
    logic [7:0] q_mag;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    assign edge_seen[0] = first_edge_seen;
    assign edge_seen[1] = second_edge_seen;
    assign edge_time[0] = first_edge_time;
    assign edge_time[1] = second_edge_time;

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            rise_stamp_next[ch]    = rise_stamp_reg[ch];
            await_fall_next[ch]    = await_fall_reg[ch];
            pulse_width_next[ch]   = pulse_width_reg[ch];
            silence_count_next[ch] = silence_count_reg[ch];
            if (edge_seen[ch])
            begin
                if (!await_fall_reg[ch])
                begin
                    rise_stamp_next[ch] = edge_time[ch];
                    await_fall_next[ch] = 1'b1;
                end
                else
                begin
                    pulse_width_next[ch]   = edge_time[ch] - rise_stamp_reg[ch];
                    await_fall_next[ch]    = 1'b0;
                    silence_count_next[ch] = '0;
                end
            end
            if (overflow_tick && (silence_count_next[ch] < SILENCE_CAP))
            begin
                silence_count_next[ch] = silence_count_next[ch] + 16'd1;
            end
        end
    end

    // Percent setup for the reported channel
    assign pw       = pulse_width_reg[sel_reg];
    assign in_range = (pw >= min_width_reg) && (pw <= max_width_reg);
    assign upper    = {1'b0, pw} > ({1'b0, center_width_reg} + {1'b0, dead_band_reg});
    assign lower    = ({1'b0, pw} + {1'b0, dead_band_reg}) < {1'b0, center_width_reg};
    assign den      = upper ? (max_width_reg - center_width_reg)
                            : (center_width_reg - min_width_reg);
    assign mag      = upper ? (pw - center_width_reg) : (center_width_reg - pw);
    assign num      = {1'b0, mag, 6'd0} + {2'b0, mag, 5'd0} + {5'b0, mag, 2'd0};
    assign zero_pct = !in_range || !(upper || lower) || (den == '0);

    assign div_req.start = (state_reg == ST_PREP) && !zero_pct;
    assign div_req.num   = num;
    assign div_req.den   = den;

    rcpd_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q_mag = (div_rsp.sat || ({1'b0, div_rsp.quo} > PCT_FULL))
                   ? PCT_FULL : {1'b0, div_rsp.quo};

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        res_width_next = res_width_reg;
        res_ok_next    = res_ok_reg;
        pct_next       = pct_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                res_width_next = pw;
                res_ok_next    = silence_count_reg[sel_reg] < timeout_limit_reg;
                neg_next       = !upper;
                pct_next       = '0;
                state_next     = zero_pct ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = neg_reg ? pct_t'(-q_mag) : pct_t'(q_mag);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            min_width_reg     <= MIN_WIDTH_RST;
            center_width_reg  <= CENTER_WIDTH_RST;
            max_width_reg     <= MAX_WIDTH_RST;
            dead_band_reg     <= DEAD_BAND_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
            for (int ch = 0; ch < 2; ch++)
            begin
                rise_stamp_reg[ch]    <= '0;
                await_fall_reg[ch]    <= 1'b0;
                pulse_width_reg[ch]   <= '0;
                silence_count_reg[ch] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_WIDTH:     min_width_reg     <= cfg_data;
                    REG_CENTER_WIDTH:  center_width_reg  <= cfg_data;
                    REG_MAX_WIDTH:     max_width_reg     <= cfg_data;
                    REG_DEAD_BAND:     dead_band_reg     <= cfg_data;
                    REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (accept)
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    rise_stamp_reg[ch]    <= rise_stamp_next[ch];
                    await_fall_reg[ch]    <= await_fall_next[ch];
                    pulse_width_reg[ch]   <= pulse_width_next[ch];
                    silence_count_reg[ch] <= silence_count_next[ch];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sel_reg <= report_channel;
        end
        neg_reg       <= neg_next;
        res_width_reg <= res_width_next;
        res_ok_reg    <= res_ok_next;
        pct_reg       <= pct_next;
        if (out_load)
        begin
            width_reg     <= res_width_reg;
            percent_reg   <= pct_reg;
            signal_ok_reg <= res_ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign width     = width_reg;
    assign percent   = percent_reg;
    assign signal_ok = signal_ok_reg;

endmodule
`default_nettype wire

// ===== sv/rcpd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC PWM decoder checker
// Port-level checks of the pulse decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcpd_checker
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire rcpd_pkg::word_t width,
    input wire rcpd_pkg::pct_t  percent,
    input wire logic            signal_ok
);
    import rcpd_pkg::*;

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent >= -8'sd100) && (percent <= 8'sd100))
        else $error("percent out of range");

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("item accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(width) && $stable(percent) && $stable(signal_ok))
        else $error("stalled result changed");

endmodule

bind rc_pwm_pulse_decoder_top rcpd_checker u_rcpd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .width     (width),
    .percent   (percent),
    .signal_ok (signal_ok)
);
`default_nettype wire

// ===== tb/rc_pwm_pulse_decoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC PWM pulse decoder checker
// Watches the register, item and result channels of the decoder, keeps its
// own copy of the edge state, silence counters and limits, works out the
// reading each accepted item should produce and compares every returned
// reading, field by field, with the oldest reading still owed.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  rcpd_pkg::cfg_idx_t cfg_index,
    input  rcpd_pkg::word_t    cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               first_edge_seen,
    input  rcpd_pkg::word_t    first_edge_time,
    input  logic               second_edge_seen,
    input  rcpd_pkg::word_t    second_edge_time,
    input  logic               overflow_tick,
    input  logic               report_channel,
    input  logic               out_valid,
    input  logic               out_ready,
    input  rcpd_pkg::word_t    width,
    input  rcpd_pkg::pct_t     percent,
    input  logic               signal_ok,
    output int                 mismatches,
    output int                 outstanding
);
    import rcpd_pkg::*;

    typedef struct packed {
        word_t width;
        pct_t  percent;
        logic  signal_ok;
    } reading_t;

    word_t    lim_min;
    word_t    lim_center;
    word_t    lim_max;
    word_t    band;
    word_t    quiet_limit;

    word_t    rise_at     [2];
    logic     fall_due    [2];
    word_t    held_width  [2];
    word_t    quiet_ticks [2];

    reading_t owed_readings [$];

    function automatic pct_t stick_percent(word_t w);
        int pw;
        int lo;
        int mid;
        int hi;
        int db;
        int span;
        int scaled;
        pw  = int'(w);
        lo  = int'(lim_min);
        mid = int'(lim_center);
        hi  = int'(lim_max);
        db  = int'(band);
        if (pw < lo || pw > hi)
            return '0;
        if (pw > mid + db)
            span = hi - mid;
        else if (pw < mid - db)
            span = mid - lo;
        else
            return '0;
        if (span == 0)
            return '0;
        scaled = (pw - mid) * int'(PCT_FULL) / span;
        if (scaled > int'(PCT_FULL))
            scaled = int'(PCT_FULL);
        if (scaled < -int'(PCT_FULL))
            scaled = -int'(PCT_FULL);
        return pct_t'(scaled);
    endfunction

    function automatic void take_capture(int ch, word_t stamp);
        if (!fall_due[ch])
        begin
            rise_at[ch]  = stamp;
            fall_due[ch] = 1'b1;
        end
        else
        begin
            held_width[ch]  = stamp - rise_at[ch];
            fall_due[ch]    = 1'b0;
            quiet_ticks[ch] = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        int       bad;
        int       ch;
        if (!rst_n)
        begin
            lim_min     = MIN_WIDTH_RST;
            lim_center  = CENTER_WIDTH_RST;
            lim_max     = MAX_WIDTH_RST;
            band        = DEAD_BAND_RST;
            quiet_limit = TIMEOUT_LIMIT_RST;
            for (ch = 0; ch < 2; ch++)
            begin
                rise_at[ch]     = '0;
                fall_due[ch]    = 1'b0;
                held_width[ch]  = '0;
                quiet_ticks[ch] = '0;
            end
            owed_readings.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_WIDTH:     lim_min     = cfg_data;
                    REG_CENTER_WIDTH:  lim_center  = cfg_data;
                    REG_MAX_WIDTH:     lim_max     = cfg_data;
                    REG_DEAD_BAND:     band        = cfg_data;
                    REG_TIMEOUT_LIMIT: quiet_limit = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (owed_readings.size() == 0)
                begin
                    $error("unexpected reading: width %0d percent %0d signal_ok %0d",
                           width, percent, signal_ok);
                    bad++;
                end
                else
                begin
                    want = owed_readings.pop_front();
                    if (width !== want.width)
                    begin
                        $error("width: expected %0d, got %0d", want.width, width);
                        bad++;
                    end
                    if (percent !== want.percent)
                    begin
                        $error("percent: expected %0d, got %0d", want.percent, percent);
                        bad++;
                    end
                    if (signal_ok !== want.signal_ok)
                    begin
                        $error("signal_ok: expected %0d, got %0d", want.signal_ok, signal_ok);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (first_edge_seen)
                    take_capture(0, first_edge_time);
                if (second_edge_seen)
                    take_capture(1, second_edge_time);
                if (overflow_tick)
                begin
                    for (ch = 0; ch < 2; ch++)
                        if (quiet_ticks[ch] < SILENCE_CAP)
                            quiet_ticks[ch] = quiet_ticks[ch] + 16'd1;
                end
                ch = report_channel ? 1 : 0;
                want.width     = held_width[ch];
                want.percent   = stick_percent(held_width[ch]);
                want.signal_ok = (quiet_ticks[ch] < quiet_limit);
                owed_readings.push_back(want);
            end
            mismatches  <= mismatches + bad;
            outstanding <= owed_readings.size();
        end
    end

endmodule

// ===== tb/rc_pwm_pulse_decoder_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC PWM pulse decoder testbench
// Drives capture items and register writes into the decoder: a short
// directed run over width extremes and zone borders, a run of overflow
// ticks against the widest timeout limits, then phases of random pulses
// under several limit settings and pacing modes. A checker beside the block
// predicts and compares every reading.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder_top_test;
    import rcpd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SATURATE_ITEMS   = 40;
    localparam int PHASES           = 10;
    localparam int PHASE_ITEMS      = 76;

    logic     clk;
    logic     rst_n            = 1'b0;
    logic     cfg_valid        = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index        = REG_MIN_WIDTH;
    word_t    cfg_data         = '0;
    logic     in_valid         = 1'b0;
    logic     in_ready;
    logic     first_edge_seen  = 1'b0;
    word_t    first_edge_time  = '0;
    logic     second_edge_seen = 1'b0;
    word_t    second_edge_time = '0;
    logic     overflow_tick    = 1'b0;
    logic     report_channel   = 1'b0;
    logic     out_valid;
    logic     out_ready        = 1'b0;
    word_t    width;
    pct_t     percent;
    logic     signal_ok;
    int       mismatches;
    int       outstanding;

    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    bit       long_hold     = 1'b0;
    int       quiet_cycles  = 0;

    word_t    cur_min    = MIN_WIDTH_RST;
    word_t    cur_center = CENTER_WIDTH_RST;
    word_t    cur_max    = MAX_WIDTH_RST;
    word_t    cur_band   = DEAD_BAND_RST;
    logic     fall_next [2] = '{1'b0, 1'b0};
    word_t    rise_mark [2] = '{16'd0, 16'd0};

    rc_pwm_pulse_decoder_top DUT (.*);

    rc_pwm_pulse_decoder_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic drive_item(logic fs, word_t ft, logic ss, word_t st, logic ovf, logic rep);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        first_edge_seen  <= fs;
        first_edge_time  <= ft;
        second_edge_seen <= ss;
        second_edge_time <= st;
        overflow_tick    <= ovf;
        report_channel   <= rep;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(word_t mn, word_t ce, word_t mx, word_t db, word_t lim);
        word_t vals [5];
        vals = '{mn, ce, mx, db, lim};
        cur_min    = mn;
        cur_center = ce;
        cur_max    = mx;
        cur_band   = db;
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_pacing(int mode);
        case (mode % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 65; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
        endcase
    endtask

    task automatic send_pulse(int ch, word_t start, word_t span);
        if (ch == 0)
        begin
            drive_item(1'b1, start, 1'b0, '0, 1'b0, 1'b0);
            drive_item(1'b1, start + span, 1'b0, '0, 1'b0, 1'b0);
        end
        else
        begin
            drive_item(1'b0, '0, 1'b1, start, 1'b0, 1'b1);
            drive_item(1'b0, '0, 1'b1, start + span, 1'b0, 1'b1);
        end
    endtask

    function automatic word_t aim_width();
        word_t key [6];
        key = '{cur_min, cur_max, cur_center + cur_band, cur_center + cur_band + 16'd1,
                cur_center - cur_band, cur_center - cur_band - 16'd1};
        if ($urandom_range(9) == 0)
            return key[$urandom_range(5)];
        if (cur_min <= cur_max)
            return cur_min - 16'd20 + word_t'($urandom_range(int'(cur_max - cur_min) + 40));
        return word_t'($urandom_range(3000));
    endfunction

    function automatic word_t next_stamp(int ch);
        word_t stamp;
        if (!fall_next[ch])
        begin
            stamp         = word_t'($urandom);
            rise_mark[ch] = stamp;
        end
        else if ($urandom_range(99) < 80)
            stamp = rise_mark[ch] + aim_width();
        else
            stamp = word_t'($urandom);
        fall_next[ch] = !fall_next[ch];
        return stamp;
    endfunction

    task automatic random_item();
        logic  fs;
        logic  ss;
        word_t ft;
        word_t st;
        fs = ($urandom_range(99) < 45);
        ss = ($urandom_range(99) < 45);
        ft = fs ? next_stamp(0) : word_t'($urandom);
        st = ss ? next_stamp(1) : word_t'($urandom);
        drive_item(fs, ft, ss, st, $urandom_range(99) < 30, 1'($urandom_range(1)));
    endtask

    task automatic pick_limits(int phase);
        word_t mn;
        word_t mx;
        case (phase)
            1: set_limits(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
            2: set_limits(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd5);
            3: set_limits(16'hFFFF, 16'd1500, 16'd0, 16'd50, 16'd20);
            4: set_limits(16'd1000, 16'd1500, 16'd2000, 16'hFFFF, SILENCE_CAP);
            5: set_limits(16'd100, 16'd200, 16'd300, 16'd0, 16'd10);
            6: set_limits(16'd1000, 16'd3000, 16'd2000, 16'd10, 16'd3);
            default:
            begin
                mn = word_t'(500 + $urandom_range(1000));
                mx = mn + word_t'($urandom_range(1500));
                set_limits(mn, word_t'($urandom_range(int'(mx), int'(mn))), mx,
                           word_t'($urandom_range(100)), word_t'($urandom_range(40)));
            end
        endcase
    endtask

    initial
    begin
        int    n;
        word_t spans [8];
        spans = '{16'd2000, 16'd1000, 16'd1551, 16'd1449, 16'd1550, 16'd1450,
                  16'd2001, 16'd999};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pacing(0);
        drive_item(1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
        drive_item(1'b0, '0, 1'b0, '0, 1'b1, 1'b1);
        drive_item(1'b1, 16'hFFF0, 1'b1, 16'h0000, 1'b0, 1'b0);
        drive_item(1'b1, 16'h05D4, 1'b1, 16'hFFFF, 1'b1, 1'b0);
        drive_item(1'b0, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b1);
        for (n = 0; n < 8; n++)
            send_pulse(n % 2, word_t'($urandom), spans[n]);
        drain();

        set_limits(MIN_WIDTH_RST, CENTER_WIDTH_RST, MAX_WIDTH_RST, DEAD_BAND_RST, 16'hFFFF);
        for (n = 0; n < SATURATE_ITEMS; n++)
            drive_item(1'b0, '0, 1'b0, '0, 1'b1, n[0]);
        drain();
        set_limits(MIN_WIDTH_RST, CENTER_WIDTH_RST, MAX_WIDTH_RST, DEAD_BAND_RST, SILENCE_CAP);
        for (n = 0; n < 4; n++)
            drive_item(1'b0, '0, 1'b0, '0, 1'b1, n[0]);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick_limits(phase);
            set_pacing(phase);
            if (phase == 0)
                long_hold = 1'b1;
            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
